// ----- rtl/swtg_pkg.sv -----
package swtg_pkg;

   localparam int AMPLITUDE = 8000;

   localparam int RATE_WIDTH  = 18;
   localparam int VOL_WIDTH   = 7;
   localparam int FREQ_WIDTH  = 16;
   localparam int MS_WIDTH    = 16;
   localparam int HP_WIDTH    = 17;
   localparam int LEFT_WIDTH  = 21;
   localparam int LEVEL_WIDTH = 15;
   localparam int SAMPLE_WIDTH = 16;

   localparam int VOL_MAX     = 100;
   localparam int VOL_SPAN    = 1 << VOL_WIDTH;
   localparam int LONGEST_MS  = 10000;
   localparam int MS_CL_WIDTH = 14;
   localparam int RATE_KHZ_DIV = 1000;
   localparam int KHZ_WIDTH   = 9;
   localparam int PROD_WIDTH  = KHZ_WIDTH + MS_CL_WIDTH;

   // rate / 1000 as (rate * ceil(2^28 / 1000)) >> 28, exact over every 18-bit rate
   localparam int KHZ_SHIFT      = 28;
   localparam int RECIP_WIDTH    = 19;
   localparam int KHZ_PROD_WIDTH = RATE_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] KHZ_RECIP = RECIP_WIDTH'(268436);

   localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(16000);
   localparam logic [VOL_WIDTH-1:0]  VOL_RESET  = VOL_WIDTH'(VOL_MAX);
   localparam logic [LEFT_WIDTH-1:0] LEFT_MAX   = '1;

   // one quotient bit per step over the whole sample rate word
   localparam int DIV_STEPS     = RATE_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_STOP   = 2'd2
   } op_type;

   typedef enum logic {
      CSR_SAMPLE_RATE = 1'b0,
      CSR_VOLUME      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_HP,
      ST_SET_KHZ,
      ST_FINISH
   } swtg_state_type;

   typedef struct packed {
      logic sample;      // produce one sample into the output register
      logic clear_left;  // end the tone
      logic load_tone;   // latch operands, start half period divide
      logic load_khz;    // keep half period, latch sample rate in kHz
      logic div_step;
      logic finish;      // commit the new tone
   } swtg_cmd_type;

   typedef struct packed {
      logic start_null;
      logic div_last;
   } swtg_status_type;

   typedef logic [LEVEL_WIDTH-1:0] level_table_type [0:VOL_SPAN-1];

   function automatic level_table_type build_levels();
      level_table_type t;
      int v;
      for (int i = 0; i < VOL_SPAN; i++) begin
         v = (i > VOL_MAX) ? VOL_MAX : i;
         t[i] = LEVEL_WIDTH'((AMPLITUDE * v) / VOL_MAX);
      end
      return t;
   endfunction

   localparam level_table_type LEVEL_TABLE = build_levels();

endpackage

// ----- rtl/swtg_ctrl.sv -----
module swtg_ctrl
   import swtg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_op,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  swtg_status_type status,
   output swtg_cmd_type    cmd
);

   swtg_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   op_type         op;

   assign op        = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && op == OP_START && !status.start_null) begin
               state_in = ST_DIV_HP;
            end
         end
         ST_DIV_HP: begin
            if (status.div_last) begin
               state_in = ST_SET_KHZ;
            end
         end
         ST_SET_KHZ: state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_SAMPLE: cmd.sample = 1'b1;
                  OP_STOP:   cmd.clear_left = 1'b1;
                  OP_START: begin
                     cmd.clear_left = status.start_null;
                     cmd.load_tone  = !status.start_null;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV_HP:  cmd.div_step = 1'b1;
         ST_SET_KHZ: cmd.load_khz = 1'b1;
         ST_FINISH:  cmd.finish   = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.sample) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/swtg_dp.sv -----
module swtg_dp
   import swtg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_index,
   input  logic [RATE_WIDTH-1:0]   csr_write_data,
   input  logic [FREQ_WIDTH-1:0]   req_frequency_hz,
   input  logic [MS_WIDTH-1:0]     req_duration_ms,
   input  swtg_cmd_type            cmd,
   output swtg_status_type         status,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_value,
   output logic                    rsp_active
);

   // configuration
   logic [RATE_WIDTH-1:0] rate_ff;
   logic [VOL_WIDTH-1:0]  vol_ff, vol_in;

   // tone state
   logic [HP_WIDTH-1:0]   half_period_ff, half_period_in;
   logic [HP_WIDTH-1:0]   phase_ff, phase_in;
   logic                  level_high_ff, level_high_in;
   logic [LEFT_WIDTH-1:0] left_ff, left_in;

   // start operands and divider
   logic [MS_CL_WIDTH-1:0]   ms_ff;
   logic                     hp_one_ff;
   logic [KHZ_WIDTH-1:0]     khz_ff;
   logic [RATE_WIDTH-1:0]    quo_ff, quo_in;
   logic [HP_WIDTH-1:0]      rem_ff, rem_in;
   logic [HP_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   // output payload
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                    active_ff, active_in;

   logic [HP_WIDTH-1:0]    highest;
   logic [FREQ_WIDTH-1:0]  freq_cl;
   logic [MS_CL_WIDTH-1:0] ms_cl;
   logic [HP_WIDTH:0]      rem_sh;
   logic [HP_WIDTH:0]      rem_diff;
   logic                   fits;
   logic [KHZ_PROD_WIDTH-1:0] khz_prod;
   logic [PROD_WIDTH-1:0]  product;
   logic [HP_WIDTH-1:0]    phase_inc;
   logic [LEVEL_WIDTH-1:0] level;
   logic [SAMPLE_WIDTH-1:0] level_ext;

   assign status.start_null = (req_frequency_hz == '0) || (req_duration_ms == '0)
                              || (rate_ff == '0);
   assign status.div_last   = (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1));

   assign highest = rate_ff[RATE_WIDTH-1:1];
   assign freq_cl = ({1'b0, req_frequency_hz} > highest) ? highest[FREQ_WIDTH-1:0]
                                                         : req_frequency_hz;
   assign ms_cl   = (req_duration_ms > MS_WIDTH'(LONGEST_MS)) ? MS_CL_WIDTH'(LONGEST_MS)
                                                             : req_duration_ms[MS_CL_WIDTH-1:0];

   // restoring divide, one quotient bit a step
   assign rem_sh   = {rem_ff, quo_ff[RATE_WIDTH-1]};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};
   assign fits     = rem_sh >= {1'b0, divisor_ff};

   assign khz_prod  = rate_ff * KHZ_RECIP;
   assign product   = khz_ff * ms_ff;
   assign phase_inc = phase_ff + 1'b1;
   assign level     = LEVEL_TABLE[vol_ff];
   assign level_ext = {1'b0, level};

   always_comb begin
      vol_in = vol_ff;
      if (csr_write_enable && csr_index_type'(csr_index) == CSR_VOLUME) begin
         vol_in = (csr_write_data[VOL_WIDTH-1:0] > VOL_WIDTH'(VOL_MAX))
                  ? VOL_WIDTH'(VOL_MAX) : csr_write_data[VOL_WIDTH-1:0];
      end
   end

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      if (cmd.load_tone) begin
         quo_in     = rate_ff;
         rem_in     = '0;
         divisor_in = {freq_cl, 1'b0};
         cnt_in     = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[RATE_WIDTH-2:0], fits};
         rem_in = fits ? rem_diff[HP_WIDTH-1:0] : rem_sh[HP_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      half_period_in = half_period_ff;
      phase_in       = phase_ff;
      level_high_in  = level_high_ff;
      left_in        = left_ff;
      sample_in      = sample_ff;
      active_in      = active_ff;
      if (cmd.clear_left) begin
         left_in = '0;
      end
      if (cmd.load_khz) begin
         // a frequency that clamps to zero gives the shortest half period
         half_period_in = hp_one_ff ? HP_WIDTH'(1) : quo_ff[HP_WIDTH-1:0];
      end
      if (cmd.finish) begin
         phase_in      = '0;
         level_high_in = 1'b1;
         left_in       = (product > PROD_WIDTH'(LEFT_MAX)) ? LEFT_MAX
                                                           : product[LEFT_WIDTH-1:0];
      end
      if (cmd.sample) begin
         if (left_ff == '0) begin
            sample_in = '0;
            active_in = 1'b0;
         end else begin
            sample_in = level_high_ff ? level_ext : (SAMPLE_WIDTH'(0) - level_ext);
            active_in = 1'b1;
            left_in   = left_ff - 1'b1;
            if (phase_inc >= half_period_ff) begin
               phase_in      = '0;
               level_high_in = !level_high_ff;
            end else begin
               phase_in = phase_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= RATE_RESET;
         vol_ff         <= VOL_RESET;
         half_period_ff <= '0;
         phase_ff       <= '0;
         level_high_ff  <= 1'b0;
         left_ff        <= '0;
         cnt_ff         <= '0;
      end else begin
         if (csr_write_enable && csr_index_type'(csr_index) == CSR_SAMPLE_RATE) begin
            rate_ff <= csr_write_data;
         end
         vol_ff         <= vol_in;
         half_period_ff <= half_period_in;
         phase_ff       <= phase_in;
         level_high_ff  <= level_high_in;
         left_ff        <= left_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tone) begin
         ms_ff     <= ms_cl;
         hp_one_ff <= (freq_cl == '0);
      end
      if (cmd.load_khz) begin
         khz_ff <= khz_prod[KHZ_SHIFT +: KHZ_WIDTH];
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      sample_ff  <= sample_in;
      active_ff  <= active_in;
   end

   assign rsp_sample_value = sample_ff;
   assign rsp_active       = active_ff;

endmodule

// ----- rtl/square_wave_tone_generator.sv -----
// channel   direction  handshake                    payload
// req       in         req_valid / req_ready        req_op, req_frequency_hz, req_duration_ms
// rsp       out        rsp_valid / rsp_ready        rsp_sample_value, rsp_active
// csr       in         csr_write_enable             csr_index, csr_write_data
//
// Sample and stop items are carried out as they are accepted; a sample item can
// be taken every cycle while the output register drains. A start item with
// nonzero operands and sample rate holds req_ready low through the bit-serial
// half period divide, a step that latches the half period and the sample rate
// in kHz, and a commit step. Synchronous reset: idle tone, 16000 Hz, 100 % volume.
// A pending result holds in the output register while rsp_ready is low.
module square_wave_tone_generator
   import swtg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_index,
   input  logic [RATE_WIDTH-1:0]   csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_op,
   input  logic [FREQ_WIDTH-1:0]   req_frequency_hz,
   input  logic [MS_WIDTH-1:0]     req_duration_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_value,
   output logic                    rsp_active
);

   swtg_cmd_type    cmd;
   swtg_status_type status;

   swtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swtg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_frequency_hz (req_frequency_hz),
      .req_duration_ms  (req_duration_ms),
      .cmd              (cmd),
      .status           (status),
      .rsp_sample_value (rsp_sample_value),
      .rsp_active       (rsp_active)
   );

endmodule
